FILE: rtl/cid_pkg.sv
// ---------------------------------------------------------------------------
// Column index of dispersion: shared package
// Field widths, payload structs and the request/response types of the shared
// add/subtract unit.
// ---------------------------------------------------------------------------
`default_nettype none

package cid_pkg;

	localparam int VAL_W    = 24;
	localparam int ROW_W    = 17;
	localparam int SUM_W    = 40;
	localparam int SQ_W     = 64;
	localparam int DISP_W   = 40;
	localparam int MAX_ROWS = 65536;
	localparam int MIN_ROWS = 2;

	// n*Q fits in 81 bits; the denominator (n-1)*S in 57 bits.
	localparam int NUM_W = SQ_W + ROW_W;
	localparam int ALU_W = NUM_W + 1;
	localparam int DEN_W = SUM_W + ROW_W;
	localparam int REM_W = DEN_W + 1;

	localparam logic [ROW_W-1:0] ROW_MIN = ROW_W'(MIN_ROWS);
	localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(MAX_ROWS);

	typedef struct packed {
		logic [VAL_W-1:0] sample_value;
		logic             last_in_column;
	} in_item_t;

	typedef struct packed {
		logic [DISP_W-1:0] dispersion;
		logic              zero_mean;
		logic              saturated;
	} out_item_t;

	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic             sub;
	} alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] sum;
		logic             carry;
	} alu_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/cid_addsub.sv
// ---------------------------------------------------------------------------
// Column index of dispersion: shared add/subtract unit
// One wide adder used for the shift-add products, the numerator difference
// and the trial subtraction of the restoring divider.
// ---------------------------------------------------------------------------
`default_nettype none

module cid_addsub (
	input  var cid_pkg::alu_req_t req,
	output var cid_pkg::alu_rsp_t rsp
);

	logic [cid_pkg::ALU_W-1:0] b_eff;
	logic [cid_pkg::ALU_W:0]   total;

	// For a subtraction, carry out high means a >= b.
	assign b_eff = req.sub ? ~req.b : req.b;
	assign total = {1'b0, req.a} + {1'b0, b_eff} + (cid_pkg::ALU_W + 1)'(req.sub);

	assign rsp.sum   = total[cid_pkg::ALU_W-1:0];
	assign rsp.carry = total[cid_pkg::ALU_W];

endmodule

`default_nettype wire

FILE: rtl/column_index_of_dispersion.sv
// ---------------------------------------------------------------------------
// Column index of dispersion
// Variance-to-mean ratio of one matrix column, streamed entry by entry.
// ---------------------------------------------------------------------------
// Each transfer on the input carries one column entry (unsigned Q16.8); rows
// that are not sent count as zero, and an all-zero column is sent as a single
// zero entry. A non-last entry is captured, then accumulated with a 24x24
// squarer. For the last entry, all products and the final division run one bit
// per cycle through a single 82-bit add/subtract unit (n*Q, then S*S, the
// difference, (n-1)*S and the restoring division). A column with a zero sum
// skips the products and the division. The result waits in an output
// register, so the next column can start while it is still pending. row_count
// is written through cfg_write and cfg_data and must only change while the
// block is idle.
// ---------------------------------------------------------------------------
`default_nettype none

module column_index_of_dispersion (
	input  var logic                       clk,
	input  var logic                       arst_n,
	input  var logic                       cfg_write,
	input  var logic [cid_pkg::ROW_W-1:0]  cfg_data,
	input  var logic                       in_valid,
	output var logic                       in_ready,
	input  var cid_pkg::in_item_t          in_data,
	output var logic                       out_valid,
	input  var logic                       out_ready,
	output var cid_pkg::out_item_t         out_data
);

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_ACC     = 8'b0000_0010,
		ST_MUL_NQ  = 8'b0000_0100,
		ST_MUL_SS  = 8'b0000_1000,
		ST_SUB     = 8'b0001_0000,
		ST_MUL_DEN = 8'b0010_0000,
		ST_DIV     = 8'b0100_0000,
		ST_FIN     = 8'b1000_0000
	} state_t;

	localparam logic [6:0] CNT_ROW = 7'(cid_pkg::ROW_W - 1);
	localparam logic [6:0] CNT_SUM = 7'(cid_pkg::SUM_W - 1);
	localparam logic [6:0] CNT_DIV = 7'(cid_pkg::NUM_W - 1);

	state_t                          state_q;
	logic [cid_pkg::ROW_W-1:0]       row_count_q;
	logic [cid_pkg::SUM_W-1:0]       sum_q;
	logic [cid_pkg::SQ_W-1:0]        sq_sum_q;
	logic                            out_valid_q;
	logic [6:0]                      cnt_q;

	logic [cid_pkg::VAL_W-1:0]       val_q;
	logic                            last_q;
	logic                            zm_q;
	logic [cid_pkg::ROW_W-1:0]       n_q;
	logic [cid_pkg::ALU_W-1:0]       mc_q;
	logic [cid_pkg::SUM_W-1:0]       mp_q;
	logic [cid_pkg::ALU_W-1:0]       acc_q;
	logic [cid_pkg::NUM_W-1:0]       num_q;
	logic [cid_pkg::DEN_W-1:0]       den_q;
	logic [cid_pkg::REM_W-1:0]       rem_q;
	logic [cid_pkg::NUM_W-1:0]       quo_q;
	cid_pkg::out_item_t              out_q;

	logic [2*cid_pkg::VAL_W-1:0]     square;
	logic [cid_pkg::SUM_W:0]         sum_ext;
	logic [cid_pkg::SQ_W:0]          sq_ext;
	logic [cid_pkg::SUM_W-1:0]       sum_next;
	logic [cid_pkg::SQ_W-1:0]        sq_next;
	logic [cid_pkg::ROW_W-1:0]       n_clamp;
	logic [cid_pkg::REM_W-1:0]       rem_shift;
	logic                            quo_over;
	logic                            out_load;
	cid_pkg::alu_req_t               alu_req;
	cid_pkg::alu_rsp_t               alu_rsp;

	cid_addsub u_addsub (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// Both accumulators saturate at all ones.
	assign square   = val_q * val_q;
	assign sum_ext  = {1'b0, sum_q} + (cid_pkg::SUM_W + 1)'(val_q);
	assign sq_ext   = {1'b0, sq_sum_q} + (cid_pkg::SQ_W + 1)'(square);
	assign sum_next = sum_ext[cid_pkg::SUM_W] ? '1 : sum_ext[cid_pkg::SUM_W-1:0];
	assign sq_next  = sq_ext[cid_pkg::SQ_W] ? '1 : sq_ext[cid_pkg::SQ_W-1:0];

	assign n_clamp = (row_count_q < cid_pkg::ROW_MIN) ? cid_pkg::ROW_MIN :
	                 (row_count_q > cid_pkg::ROW_MAX) ? cid_pkg::ROW_MAX : row_count_q;

	assign rem_shift = {rem_q[cid_pkg::REM_W-2:0], num_q[cid_pkg::NUM_W-1]};
	assign quo_over  = |quo_q[cid_pkg::NUM_W-1:cid_pkg::DISP_W];
	assign out_load  = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		alu_req.a   = acc_q;
		alu_req.b   = mp_q[0] ? mc_q : '0;
		alu_req.sub = 1'b0;
		unique case (state_q)
			ST_SUB: begin
				alu_req.a   = cid_pkg::ALU_W'(num_q);
				alu_req.b   = acc_q;
				alu_req.sub = 1'b1;
			end
			ST_DIV: begin
				alu_req.a   = cid_pkg::ALU_W'(rem_shift);
				alu_req.b   = cid_pkg::ALU_W'(den_q);
				alu_req.sub = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_count_q <= cid_pkg::ROW_MIN;
			sum_q       <= '0;
			sq_sum_q    <= '0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cfg_write) begin
				row_count_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					sum_q    <= sum_next;
					sq_sum_q <= sq_next;
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (sum_next == '0) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_MUL_NQ;
						cnt_q   <= CNT_ROW;
					end
				end
				ST_MUL_NQ: begin
					if (cnt_q == '0) begin
						state_q <= ST_MUL_SS;
						cnt_q   <= CNT_SUM;
					end else begin
						cnt_q <= cnt_q - 7'd1;
					end
				end
				ST_MUL_SS: begin
					if (cnt_q == '0) begin
						state_q <= ST_SUB;
					end else begin
						cnt_q <= cnt_q - 7'd1;
					end
				end
				ST_SUB: begin
					state_q <= ST_MUL_DEN;
					cnt_q   <= CNT_ROW;
				end
				ST_MUL_DEN: begin
					if (cnt_q == '0) begin
						state_q <= ST_DIV;
						cnt_q   <= CNT_DIV;
					end else begin
						cnt_q <= cnt_q - 7'd1;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q - 7'd1;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						sum_q    <= '0;
						sq_sum_q <= '0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					val_q  <= in_data.sample_value;
					last_q <= in_data.last_in_column;
				end
			end
			ST_ACC: begin
				zm_q  <= (sum_next == '0);
				n_q   <= n_clamp;
				mc_q  <= cid_pkg::ALU_W'(sq_next);
				mp_q  <= cid_pkg::SUM_W'(n_clamp);
				acc_q <= '0;
			end
			ST_MUL_NQ: begin
				if (cnt_q == '0) begin
					num_q <= alu_rsp.sum[cid_pkg::NUM_W-1:0];
					mc_q  <= cid_pkg::ALU_W'(sum_q);
					mp_q  <= sum_q;
					acc_q <= '0;
				end else begin
					acc_q <= alu_rsp.sum;
					mc_q  <= mc_q << 1;
					mp_q  <= mp_q >> 1;
				end
			end
			ST_MUL_SS: begin
				acc_q <= alu_rsp.sum;
				mc_q  <= mc_q << 1;
				mp_q  <= mp_q >> 1;
			end
			ST_SUB: begin
				// A negative numerator only follows from overfull or saturated
				// columns and is taken as zero.
				num_q <= alu_rsp.carry ? alu_rsp.sum[cid_pkg::NUM_W-1:0] : '0;
				mc_q  <= cid_pkg::ALU_W'(sum_q);
				mp_q  <= cid_pkg::SUM_W'(n_q - cid_pkg::ROW_W'(1));
				acc_q <= '0;
			end
			ST_MUL_DEN: begin
				acc_q <= alu_rsp.sum;
				mc_q  <= mc_q << 1;
				mp_q  <= mp_q >> 1;
				if (cnt_q == '0) begin
					den_q <= alu_rsp.sum[cid_pkg::DEN_W-1:0];
					rem_q <= '0;
					quo_q <= '0;
				end
			end
			ST_DIV: begin
				num_q <= num_q << 1;
				if (alu_rsp.carry) begin
					rem_q <= alu_rsp.sum[cid_pkg::REM_W-1:0];
					quo_q <= {quo_q[cid_pkg::NUM_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_shift;
					quo_q <= {quo_q[cid_pkg::NUM_W-2:0], 1'b0};
				end
			end
			ST_FIN: begin
				if (out_load) begin
					out_q.zero_mean  <= zm_q;
					out_q.saturated  <= !zm_q && quo_over;
					out_q.dispersion <= zm_q     ? '0 :
					                    quo_over ? '1 : quo_q[cid_pkg::DISP_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A zero-mean result carries neither a quotient nor a clamp.
	a_zero_mean_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.zero_mean |-> out_data.dispersion == '0 && !out_data.saturated)
		else $error("zero-mean result with nonzero dispersion or saturation");

	a_sat_all_ones: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.saturated |-> out_data.dispersion == '1)
		else $error("saturated result not clamped to all ones");

	// The restoring divider keeps its partial remainder below the divisor.
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < cid_pkg::REM_W'(den_q))
		else $error("divider remainder not below divisor");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while previous entry still in work");

	a_acc_hold_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL_SS || state_q == ST_DIV |=> $stable(sum_q) && $stable(sq_sum_q))
		else $error("accumulators changed during the column computation");

endmodule

`default_nettype wire

FILE: test/column_index_of_dispersion_tb.sv
// ---------------------------------------------------------------------------
// Column index of dispersion: self-checking testbench
// Streams matrix columns into the block, predicts each variance-to-mean ratio
// from its own running sums and compares every result field by field. The
// row count is changed between phases, including out-of-range settings.
// ---------------------------------------------------------------------------

module column_index_of_dispersion_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES   = 200;
	localparam int CYCLE_LIMIT     = 3_000_000;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_write = 1'b0;
	logic [cid_pkg::ROW_W-1:0] cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	cid_pkg::in_item_t         in_data = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	cid_pkg::out_item_t        out_data;

	// Predictor state, kept in step with the block.
	logic [cid_pkg::ROW_W-1:0] rows_setting = cid_pkg::ROW_MIN;
	logic [cid_pkg::SUM_W-1:0] column_sum = '0;
	logic [cid_pkg::SQ_W-1:0]  column_square_sum = '0;

	cid_pkg::in_item_t  queued_entries[$];
	cid_pkg::out_item_t expected_ratios[$];

	int  entries_sent = 0;
	int  entries_accepted = 0;
	int  ratios_received = 0;
	int  ratios_paced = 0;
	int  zero_mean_columns = 0;
	int  row_settings = 0;
	int  mismatches = 0;
	int  cycle_count = 0;
	int  entry_gap = 0;
	int  stall_left = 0;
	bit  quiet = 1'b0;

	column_index_of_dispersion i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Variance over n rows divided by the mean, from the raw-code sums.
	function automatic cid_pkg::out_item_t ratio_of_column(
		input logic [cid_pkg::SUM_W-1:0] sum,
		input logic [cid_pkg::SQ_W-1:0]  square_sum,
		input logic [cid_pkg::ROW_W-1:0] rows
	);
		cid_pkg::out_item_t        ratio;
		logic [cid_pkg::ROW_W-1:0] n;
		logic [127:0]              n_wide, s_wide, q_wide, nq, ss, num, den, quo;
		ratio = '0;
		if (sum == '0) begin
			ratio.zero_mean = 1'b1;
			return ratio;
		end
		n = (rows < cid_pkg::ROW_MIN) ? cid_pkg::ROW_MIN :
			(rows > cid_pkg::ROW_MAX) ? cid_pkg::ROW_MAX : rows;
		n_wide = 128'(n);
		s_wide = 128'(sum);
		q_wide = 128'(square_sum);
		nq = n_wide * q_wide;
		ss = s_wide * s_wide;
		// More entries than rows, or saturated sums, can drive the numerator
		// below zero; it is then taken as zero.
		num = (nq >= ss) ? nq - ss : '0;
		den = (n_wide - 128'd1) * s_wide;
		quo = num / den;
		if (quo > 128'({cid_pkg::DISP_W{1'b1}})) begin
			ratio.dispersion = '1;
			ratio.saturated  = 1'b1;
		end else begin
			ratio.dispersion = quo[cid_pkg::DISP_W-1:0];
		end
		return ratio;
	endfunction

	task automatic accumulate_entry(input cid_pkg::in_item_t item);
		logic [47:0]             value, square;
		logic [cid_pkg::SUM_W:0] sum_next;
		logic [cid_pkg::SQ_W:0]  square_next;
		value = 48'(item.sample_value);
		square = value * value;
		sum_next = {1'b0, column_sum} + (cid_pkg::SUM_W + 1)'(item.sample_value);
		square_next = {1'b0, column_square_sum} + (cid_pkg::SQ_W + 1)'(square);
		column_sum = sum_next[cid_pkg::SUM_W] ? '1 : sum_next[cid_pkg::SUM_W-1:0];
		column_square_sum = square_next[cid_pkg::SQ_W] ? '1 :
			square_next[cid_pkg::SQ_W-1:0];
		if (item.last_in_column) begin
			expected_ratios = {expected_ratios,
				ratio_of_column(column_sum, column_square_sum, rows_setting)};
			if (column_sum == '0)
				zero_mean_columns++;
			column_sum = '0;
			column_square_sum = '0;
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [cid_pkg::VAL_W-1:0] random_value();
		logic [cid_pkg::VAL_W-1:0] value;
		int                        r;
		r = $urandom_range(0, 99);
		if (r < 20)
			value = '0;
		else if (r < 50)
			value = cid_pkg::VAL_W'($urandom_range(1, 2048));
		else if (r < 90)
			value = cid_pkg::VAL_W'($urandom());
		else
			value = '1;
		return value;
	endfunction

	// Input driver: a new entry is presented only after the previous transfer.
	always @(negedge clk) begin
		if (entries_sent == entries_accepted) begin
			if (entry_gap > 0) begin
				entry_gap--;
				in_valid <= 1'b0;
			end else if (queued_entries.size() != 0) begin
				in_data <= queued_entries.pop_front();
				in_valid <= 1'b1;
				entries_sent++;
				entry_gap = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result side back-pressure: a stall after some transfers, and now and then
	// while a result is still being computed.
	always @(negedge clk) begin
		if (ratios_received != ratios_paced) begin
			ratios_paced = ratios_received;
			stall_left = pick_gap();
		end else if (stall_left == 0 && !quiet && $urandom_range(0, 99) < 2) begin
			stall_left = $urandom_range(1, 30);
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Monitor and predictor. The result is checked before the input transfer of
	// the same edge is predicted, so a fresh expectation is never matched early.
	always @(posedge clk) begin
		cid_pkg::out_item_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
		if (cfg_write)
			rows_setting = cfg_data;
		if (out_valid && out_ready) begin
			ratios_received <= ratios_received + 1;
			if (expected_ratios.size() == 0) begin
				$error("result with no column pending: dispersion %0d", out_data.dispersion);
				mismatches++;
			end else begin
				want = expected_ratios.pop_front();
				if (out_data.dispersion !== want.dispersion) begin
					$error("dispersion: expected %0d, got %0d", want.dispersion,
						out_data.dispersion);
					mismatches++;
				end
				if (out_data.zero_mean !== want.zero_mean) begin
					$error("zero_mean: expected %0b, got %0b", want.zero_mean,
						out_data.zero_mean);
					mismatches++;
				end
				if (out_data.saturated !== want.saturated) begin
					$error("saturated: expected %0b, got %0b", want.saturated,
						out_data.saturated);
					mismatches++;
				end
			end
		end
		if (in_valid && in_ready) begin
			entries_accepted <= entries_accepted + 1;
			accumulate_entry(in_data);
		end
	end

	task automatic push_entry(input logic [cid_pkg::VAL_W-1:0] value, input bit last);
		cid_pkg::in_item_t item;
		item.sample_value = value;
		item.last_in_column = last;
		queued_entries = {queued_entries, item};
	endtask

	task automatic push_column(input int length);
		for (int k = 1; k <= length; k++)
			push_entry(random_value(), k == length);
	endtask

	// Waits until every entry is taken and every result is in, then lets the
	// block finish any work that produces no result.
	task automatic wait_idle();
		while (queued_entries.size() != 0 || entries_sent != entries_accepted ||
			expected_ratios.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_rows(input logic [cid_pkg::ROW_W-1:0] rows);
		wait_idle();
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_data <= rows;
		@(negedge clk);
		cfg_write <= 1'b0;
		row_settings++;
	endtask

	task automatic run_random_phase(input logic [cid_pkg::ROW_W-1:0] rows,
		input int entry_budget, input bit no_idling);
		int n_eff, pushed, length, r;
		set_rows(rows);
		quiet = no_idling;
		n_eff = (rows < cid_pkg::ROW_MIN) ? cid_pkg::MIN_ROWS :
			(rows > cid_pkg::ROW_MAX) ? cid_pkg::MAX_ROWS : int'(rows);
		pushed = 0;
		while (pushed < entry_budget) begin
			r = $urandom_range(0, 99);
			if (r < 80)
				length = $urandom_range(1, (n_eff < 16) ? n_eff : 16);
			else if (r < 88)
				length = (n_eff <= 300) ? n_eff : $urandom_range(17, 64);
			else
				length = $urandom_range(1, 40);
			push_column(length);
			pushed += length;
		end
		wait_idle();
		quiet = 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Row count left at its reset value of two.
		row_settings++;
		push_entry('0, 1'b1);
		push_entry('1, 1'b0);
		push_entry('0, 1'b1);
		push_entry(24'd1, 1'b1);
		push_entry(24'h000100, 1'b0);
		push_entry(24'h000300, 1'b1);

		// Zero clamps to two; three entries then give a negative numerator.
		set_rows('0);
		push_entry('1, 1'b0);
		push_entry('1, 1'b1);
		push_entry(24'd5, 1'b0);
		push_entry(24'd7, 1'b0);
		push_entry(24'd9, 1'b1);

		set_rows(17'd1);
		push_entry(24'd1000, 1'b0);
		push_entry('0, 1'b1);

		// All ones clamps to the largest row count.
		set_rows('1);
		push_entry('1, 1'b1);
		push_entry(24'hAAAAAA, 1'b0);
		push_entry(24'h555555, 1'b1);

		set_rows(cid_pkg::ROW_MAX);
		push_entry(24'h123456, 1'b0);
		push_entry('0, 1'b0);
		push_entry('1, 1'b1);

		run_random_phase(17'd2, 250, 1'b0);
		run_random_phase(17'd3, 250, 1'b0);
		run_random_phase(17'($urandom_range(4, 40)), 250, 1'b1);
		run_random_phase(17'($urandom_range(41, 300)), 250, 1'b0);
		run_random_phase(cid_pkg::ROW_MAX, 250, 1'b0);
		run_random_phase(17'($urandom()), 250, 1'b0);

		wait_idle();
		$display("Checked %0d column results from %0d entries over %0d row-count settings",
			ratios_received, entries_accepted, row_settings);
		$display("%0d columns had a zero mean; row counts outside the legal range were included",
			zero_mean_columns);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: sim.f
rtl/cid_pkg.sv
rtl/cid_addsub.sv
rtl/column_index_of_dispersion.sv
test/column_index_of_dispersion_tb.sv
